// ===== rtl/core/dwips_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwips_pkg
// Shared widths, register indexes and control types for the dual-wheel
// incremental PI speed controller.
// ----------------------------------------------------------------------------
package dwips_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned FRAC_BITS      = 8;
  localparam int unsigned POSITION_WIDTH = 48;

  // Fixed field widths
  localparam int unsigned DATA_W    = 16;  // targets, encoder counts, drives
  localparam int unsigned GAIN_W    = 16;  // kp, ki (Q8.8)
  localparam int unsigned MAX_W     = 15;  // max_out
  localparam int unsigned ERR_W     = 18;  // target - speed
  localparam int unsigned DIFF_W    = 19;  // error - last error
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Register reset values
  localparam logic [GAIN_W-1:0] KP_RESET      = 16'd256;
  localparam logic [GAIN_W-1:0] KI_RESET      = 16'd0;
  localparam logic [MAX_W-1:0]  MAX_OUT_RESET = 15'd32767;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP      = 2'd0,
    CFG_KI      = 2'd1,
    CFG_MAX_OUT = 2'd2
  } cfg_idx_e;

  // Gains and limit, seen by both lanes
  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [MAX_W-1:0]  max_out;
  } gains_t;

  // Pipeline strobes from the top level into each lane
  typedef struct packed {
    logic s1_load;  // beat accepted, error stage loads
    logic s1_stop;  // accepted beat is a stop tick
    logic s2_load;  // product stage loads
    logic s3_load;  // accumulator stage loads
    logic s3_stop;  // beat entering the accumulator stage is a stop tick
  } lane_ctrl_t;

endpackage

// ===== rtl/core/dwips_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwips interfaces
// Valid/ready channels for input beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface dwips_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dwips_pkg::DATA_W-1:0]  target_left;
  logic signed [dwips_pkg::DATA_W-1:0]  target_right;
  logic signed [dwips_pkg::DATA_W-1:0]  encoder_left;
  logic signed [dwips_pkg::DATA_W-1:0]  encoder_right;

  modport source (output valid, target_left, target_right, encoder_left, encoder_right,
                  input ready);
  modport sink   (input valid, target_left, target_right, encoder_left, encoder_right,
                  output ready);
endinterface

interface dwips_out_if #(
  parameter int unsigned PosWidth = dwips_pkg::POSITION_WIDTH
);
  logic                                 valid;
  logic                                 ready;
  logic signed [dwips_pkg::DATA_W-1:0]  drive_left;
  logic signed [dwips_pkg::DATA_W-1:0]  drive_right;
  logic                                 stopped;
  logic signed [PosWidth-1:0]           position_left;
  logic signed [PosWidth-1:0]           position_right;

  modport source (output valid, drive_left, drive_right, stopped, position_left,
                  position_right, input ready);
  modport sink   (input valid, drive_left, drive_right, stopped, position_left,
                  position_right, output ready);
endinterface

interface dwips_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [dwips_pkg::CFG_IDX_W-1:0]     index;
  logic [dwips_pkg::CFG_DAT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/dwips_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwips_lane
// One wheel's PI core: error and error change, gain products, then the
// accumulate-and-clamp loop that holds the drive accumulator.
// ----------------------------------------------------------------------------
module dwips_lane #(
  parameter int unsigned FRAC_BITS = dwips_pkg::FRAC_BITS,
  localparam int unsigned AccW     = 17 + FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dwips_pkg::lane_ctrl_t               ctrl_i,
  input  dwips_pkg::gains_t                   gains_i,
  input  logic signed [dwips_pkg::DATA_W-1:0] target_i,
  input  logic signed [dwips_pkg::DATA_W-1:0] speed_i,
  output logic signed [AccW-1:0]              accum_o
);

  localparam int unsigned ErrW   = dwips_pkg::ERR_W;
  localparam int unsigned DiffW  = dwips_pkg::DIFF_W;
  localparam int unsigned GainW  = dwips_pkg::GAIN_W;
  localparam int unsigned ProdPW = GainW + 1 + DiffW;
  localparam int unsigned ProdIW = GainW + 1 + ErrW;
  localparam int unsigned SumW   = ((ProdPW > AccW) ? ProdPW : AccW) + 2;

  logic signed [ErrW-1:0]   err_d, last_err_q, err_q;
  logic signed [DiffW-1:0]  diff_d, diff_q;
  logic signed [GainW:0]    kp_s, ki_s;
  logic signed [ProdPW-1:0] prod_p_d, prod_p_q;
  logic signed [ProdIW-1:0] prod_i_d, prod_i_q;
  logic signed [SumW-1:0]   sum, lim, clamped;
  logic signed [AccW-1:0]   accum_d, accum_q;

  // Error and its change against the last non-stop tick
  always_comb begin
    err_d  = ErrW'(target_i) - ErrW'(speed_i);
    diff_d = DiffW'(err_d) - DiffW'(last_err_q);
  end

  // Gain products, gains are unsigned
  always_comb begin
    kp_s     = $signed({1'b0, gains_i.kp});
    ki_s     = $signed({1'b0, gains_i.ki});
    prod_p_d = kp_s * diff_q;
    prod_i_d = ki_s * err_q;
  end

  // Accumulate and clamp to +-max_out in accumulator scale
  always_comb begin
    sum = SumW'(accum_q) + SumW'(prod_p_q) + SumW'(prod_i_q);
    lim = SumW'(gains_i.max_out) << FRAC_BITS;
    if (sum > lim) begin
      clamped = lim;
    end else if (sum < -lim) begin
      clamped = -lim;
    end else begin
      clamped = sum;
    end
    accum_d = ctrl_i.s3_stop ? '0 : AccW'(clamped);
  end

  // State: last error and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      accum_q    <= '0;
    end else begin
      if (ctrl_i.s1_load && !ctrl_i.s1_stop) begin
        last_err_q <= err_d;
      end
      if (ctrl_i.s3_load) begin
        accum_q <= accum_d;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_load) begin
      err_q  <= err_d;
      diff_q <= diff_d;
    end
    if (ctrl_i.s2_load) begin
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
    end
  end

  assign accum_o = accum_q;

  // A stop beat always leaves a cleared accumulator
  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.s3_load && ctrl_i.s3_stop |=> accum_q == '0)
    else $error("accumulator not cleared on stop");

  // Last error holds across stop ticks
  a_stop_keeps_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.s1_load && ctrl_i.s1_stop |=> $stable(last_err_q))
    else $error("last error changed on stop");

  // Accumulator moves only when its stage loads
  a_accum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.s3_load |=> $stable(accum_q))
    else $error("accumulator changed without a load");

endmodule

// ===== rtl/core/dwips_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwips_merge
// Result register: joins both lanes' accumulators, truncated toward zero,
// with the stop flag and the wheel positions into one result beat.
// ----------------------------------------------------------------------------
module dwips_merge #(
  parameter int unsigned FRAC_BITS      = dwips_pkg::FRAC_BITS,
  parameter int unsigned POSITION_WIDTH = dwips_pkg::POSITION_WIDTH,
  localparam int unsigned AccW          = 17 + FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic                                stop_i,
  input  logic signed [AccW-1:0]              accum_left_i,
  input  logic signed [AccW-1:0]              accum_right_i,
  input  logic [POSITION_WIDTH-1:0]           pos_left_i,
  input  logic [POSITION_WIDTH-1:0]           pos_right_i,
  output logic signed [dwips_pkg::DATA_W-1:0] drive_left_o,
  output logic signed [dwips_pkg::DATA_W-1:0] drive_right_o,
  output logic                                stopped_o,
  output logic [POSITION_WIDTH-1:0]           position_left_o,
  output logic [POSITION_WIDTH-1:0]           position_right_o
);

  localparam int unsigned DataW = dwips_pkg::DATA_W;
  localparam logic [AccW-1:0] Bias = AccW'((64'd1 << FRAC_BITS) - 64'd1);

  // Drop fraction bits, rounding toward zero
  function automatic logic signed [DataW-1:0] to_drive(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] biased;
    logic signed [AccW-1:0] shifted;
    biased  = acc + (acc[AccW-1] ? $signed(Bias) : '0);
    shifted = biased >>> FRAC_BITS;
    return DataW'(shifted);
  endfunction

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      drive_left_o     <= to_drive(accum_left_i);
      drive_right_o    <= to_drive(accum_right_i);
      stopped_o        <= stop_i;
      position_left_o  <= pos_left_i;
      position_right_o <= pos_right_i;
    end
  end

endmodule

// ===== rtl/core/dual_wheel_incremental_pi_speed.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_wheel_incremental_pi_speed
// Two-wheel incremental PI speed controller, one control tick per beat.
// ----------------------------------------------------------------------------
// Each input beat is one control tick: it takes a beat every cycle when the
// output is not held off and gives one result beat per accepted beat. The
// beat passes an error stage, a gain-product stage, the per-wheel
// accumulate-and-clamp stage (the only feedback path) and the result
// register; a stall at the output backs the stages up one at a time, so
// empty stages still accept. The left encoder count is negated.
// Both targets zero is a stop tick: accumulators clear, drives read zero,
// stopped is set, last errors hold, positions still advance. Register
// writes (0 kp, 1 ki, 2 max_out; index 3 is ignored) are always ready and
// belong to idle periods.
// ----------------------------------------------------------------------------
module dual_wheel_incremental_pi_speed #(
  parameter int unsigned FRAC_BITS      = dwips_pkg::FRAC_BITS,
  parameter int unsigned POSITION_WIDTH = dwips_pkg::POSITION_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  dwips_cfg_if.sink          cfg_i,
  dwips_in_if.sink           in_i,
  dwips_out_if.source        out_o
);

  localparam int unsigned AccW  = 17 + FRAC_BITS;
  localparam int unsigned DataW = dwips_pkg::DATA_W;
  localparam int unsigned PosW  = POSITION_WIDTH;

  dwips_pkg::gains_t     gains_q;
  dwips_pkg::lane_ctrl_t lane_ctrl;

  logic v1_q, v2_q, v3_q, vo_q;
  logic mv1, mv2, mv3;
  logic in_acc, stop_in;
  logic stop1_q, stop2_q, stop3_q;
  logic signed [DataW-1:0] speed_l, speed_r;
  logic [PosW-1:0] pos_l_q, pos_r_q, pos_l_d, pos_r_d;
  logic [PosW-1:0] posl_pipe_q [3];
  logic [PosW-1:0] posr_pipe_q [3];
  logic signed [AccW-1:0] accum_l, accum_r;
  logic [PosW-1:0] pos_out_l, pos_out_r;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.kp      <= dwips_pkg::KP_RESET;
      gains_q.ki      <= dwips_pkg::KI_RESET;
      gains_q.max_out <= dwips_pkg::MAX_OUT_RESET;
    end else if (cfg_i.valid) begin
      case (dwips_pkg::cfg_idx_e'(cfg_i.index))
        dwips_pkg::CFG_KP:      gains_q.kp      <= cfg_i.data;
        dwips_pkg::CFG_KI:      gains_q.ki      <= cfg_i.data;
        dwips_pkg::CFG_MAX_OUT: gains_q.max_out <= cfg_i.data[dwips_pkg::MAX_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage advance: a stage moves when the next one is empty or moving
  always_comb begin
    mv3         = v3_q && (!vo_q || out_o.ready);
    mv2         = v2_q && (!v3_q || mv3);
    mv1         = v1_q && (!v2_q || mv2);
    in_i.ready  = !v1_q || mv1;
    in_acc      = in_i.valid && in_i.ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (in_i.ready) v1_q <= in_i.valid;
      if (!v2_q || mv2) v2_q <= mv1;
      if (!v3_q || mv3) v3_q <= mv2;
      if (!vo_q || out_o.ready) vo_q <= mv3;
    end
  end

  // Speeds, stop detect and wrapping positions
  always_comb begin
    speed_l = DataW'(-in_i.encoder_left);
    speed_r = in_i.encoder_right;
    stop_in = (in_i.target_left == '0) && (in_i.target_right == '0);
    pos_l_d = pos_l_q + PosW'(speed_l);
    pos_r_d = pos_r_q + PosW'(speed_r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_l_q <= '0;
      pos_r_q <= '0;
    end else if (in_acc) begin
      pos_l_q <= pos_l_d;
      pos_r_q <= pos_r_d;
    end
  end

  // Side payload that travels with each beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stop1_q        <= stop_in;
      posl_pipe_q[0] <= pos_l_d;
      posr_pipe_q[0] <= pos_r_d;
    end
    if (mv1) begin
      stop2_q        <= stop1_q;
      posl_pipe_q[1] <= posl_pipe_q[0];
      posr_pipe_q[1] <= posr_pipe_q[0];
    end
    if (mv2) begin
      stop3_q        <= stop2_q;
      posl_pipe_q[2] <= posl_pipe_q[1];
      posr_pipe_q[2] <= posr_pipe_q[1];
    end
  end

  // Lane strobes
  always_comb begin
    lane_ctrl.s1_load = in_acc;
    lane_ctrl.s1_stop = stop_in;
    lane_ctrl.s2_load = mv1;
    lane_ctrl.s3_load = mv2;
    lane_ctrl.s3_stop = stop2_q;
  end

  dwips_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .gains_i  (gains_q),
    .target_i (in_i.target_left),
    .speed_i  (speed_l),
    .accum_o  (accum_l)
  );

  dwips_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .gains_i  (gains_q),
    .target_i (in_i.target_right),
    .speed_i  (speed_r),
    .accum_o  (accum_r)
  );

  dwips_merge #(
    .FRAC_BITS      (FRAC_BITS),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_merge (
    .clk_i            (clk_i),
    .load_i           (mv3),
    .stop_i           (stop3_q),
    .accum_left_i     (accum_l),
    .accum_right_i    (accum_r),
    .pos_left_i       (posl_pipe_q[2]),
    .pos_right_i      (posr_pipe_q[2]),
    .drive_left_o     (out_o.drive_left),
    .drive_right_o    (out_o.drive_right),
    .stopped_o        (out_o.stopped),
    .position_left_o  (pos_out_l),
    .position_right_o (pos_out_r)
  );

  assign out_o.valid          = vo_q;
  assign out_o.position_left  = pos_out_l;
  assign out_o.position_right = pos_out_r;

  // A stop beat carries zero drives
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.stopped |-> out_o.drive_left == '0 && out_o.drive_right == '0)
    else $error("stop beat with nonzero drive");

  // An accepted beat lands in the error stage
  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v1_q)
    else $error("accepted beat lost");

  // A held accumulator-stage beat stays put
  a_s3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !mv3 |=> v3_q)
    else $error("stalled beat dropped");

  // A full, stalled pipe takes nothing in
  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q && v3_q && vo_q && !out_o.ready |-> !in_i.ready)
    else $error("input ready while pipe full");

endmodule

// ===== test/dual_wheel_incremental_pi_speed_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_wheel_incremental_pi_speed_tb
// Self-checking bench for the two-wheel incremental PI speed controller.
// Control ticks and register writes go in over valid/ready channels, with
// random idle gaps on the sender and the receiver. A behavioral copy of the
// controller predicts each result beat, and every result beat is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module dual_wheel_incremental_pi_speed_tb;

  localparam int unsigned PosW           = dwips_pkg::POSITION_WIDTH;
  localparam int unsigned DataW          = dwips_pkg::DATA_W;
  localparam int unsigned FracBits       = dwips_pkg::FRAC_BITS;
  localparam int unsigned PipeLatency    = 4;
  localparam int unsigned LongHoldCycles = 64;
  localparam int unsigned StallLimit     = 2000;
  localparam int unsigned PhaseTicks     = 280;

  // Index with no register behind it; writes to it must be dropped
  localparam logic [dwips_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef logic signed [DataW-1:0] count_t;

  typedef struct packed {
    count_t          drive_left;
    count_t          drive_right;
    logic            stopped;
    logic [PosW-1:0] position_left;
    logic [PosW-1:0] position_right;
  } drive_beat_t;

  logic clk;
  logic rst_n;

  dwips_cfg_if                      cfg_if ();
  dwips_in_if                       tick_if ();
  dwips_out_if #(.PosWidth(PosW))   drive_if ();

  dual_wheel_incremental_pi_speed dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (tick_if),
    .out_o  (drive_if)
  );

  // Controller copy: registers and per-wheel state
  longint          kp_gain;
  longint          ki_gain;
  longint          drive_limit;
  longint          err_prev_l;
  longint          err_prev_r;
  longint          accum_l;
  longint          accum_r;
  logic [PosW-1:0] odo_l;
  logic [PosW-1:0] odo_r;

  drive_beat_t pending_drives[$];
  int unsigned mismatches;
  int unsigned quiet_cycles;

  // Idle gap controls and long receiver hold-off requests
  bit          src_gaps_on;
  bit          sink_gaps_on;
  int unsigned hold_requests;
  int unsigned holds_served;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Controller prediction
  // ---------------------------------------------------------------------------

  // One incremental PI update of a drive accumulator, clamped to the limit
  function automatic longint pi_step(longint accum, longint err, longint err_prev);
    longint lim;
    longint sum;
    lim = drive_limit <<< FracBits;
    sum = accum + kp_gain * (err - err_prev) + ki_gain * err;
    if (sum > lim) sum = lim;
    else if (sum < -lim) sum = -lim;
    return sum;
  endfunction

  task automatic predict_tick(input count_t tl, input count_t tr, input count_t el,
                              input count_t er);
    count_t      spd_l;
    longint      err_l;
    longint      err_r;
    longint      whole;
    drive_beat_t beat;
    // left encoder counts backwards; -32768 wraps onto itself
    spd_l = -el;
    odo_l = odo_l + {{(PosW-DataW){spd_l[DataW-1]}}, spd_l};
    odo_r = odo_r + {{(PosW-DataW){er[DataW-1]}}, er};
    beat.position_left  = odo_l;
    beat.position_right = odo_r;
    beat.stopped        = (tl == 0) && (tr == 0);
    if (beat.stopped) begin
      // stop tick: clear drives, keep error memory
      accum_l = 0;
      accum_r = 0;
    end else begin
      err_l      = longint'(tl) - longint'(spd_l);
      err_r      = longint'(tr) - longint'(er);
      accum_l    = pi_step(accum_l, err_l, err_prev_l);
      accum_r    = pi_step(accum_r, err_r, err_prev_r);
      err_prev_l = err_l;
      err_prev_r = err_r;
    end
    // signed divide truncates toward zero
    whole = accum_l / (longint'(1) <<< FracBits);
    beat.drive_left = whole[DataW-1:0];
    whole = accum_r / (longint'(1) <<< FracBits);
    beat.drive_right = whole[DataW-1:0];
    pending_drives.push_back(beat);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one control tick; predict it once the beat is taken
  task automatic send_tick(input count_t tl, input count_t tr, input count_t el,
                           input count_t er);
    int unsigned gap;
    gap = src_gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_if.valid         <= 1'b1;
    tick_if.target_left   <= tl;
    tick_if.target_right  <= tr;
    tick_if.encoder_left  <= el;
    tick_if.encoder_right <= er;
    do @(posedge clk); while (!tick_if.ready);
    predict_tick(tl, tr, el, er);
  endtask

  // Mostly modest speeds, sometimes full range or a corner value
  function automatic count_t pick_speed();
    case ($urandom_range(0, 9))
      0: return count_t'($urandom);
      1: begin
        case ($urandom_range(0, 5))
          0:       return 16'sh8000;
          1:       return 16'sh8001;
          2:       return 16'sh7FFF;
          3:       return 16'sh0001;
          4:       return 16'shFFFF;
          default: return 16'sh0000;
        endcase
      end
      default: return count_t'($urandom_range(0, 600)) - 16'sd300;
    endcase
  endfunction

  task automatic random_tick();
    count_t tl;
    count_t tr;
    count_t el;
    count_t er;
    if ($urandom_range(0, 9) == 0) begin
      tl = 0;
      tr = 0;
    end else begin
      tl = pick_speed();
      tr = pick_speed();
    end
    // encoders mostly track the targets, left one counting backwards
    if ($urandom_range(0, 3) == 0) begin
      el = pick_speed();
      er = pick_speed();
    end else begin
      el = -(tl + count_t'($urandom_range(0, 16)) - 16'sd8);
      er = tr + count_t'($urandom_range(0, 16)) - 16'sd8;
    end
    send_tick(tl, tr, el, er);
  endtask

  // Stop offering ticks and wait until every result is back
  task automatic settle();
    tick_if.valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (PipeLatency + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dwips_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dwips_pkg::CFG_DAT_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      dwips_pkg::CFG_KP:      kp_gain     = data;
      dwips_pkg::CFG_KI:      ki_gain     = data;
      dwips_pkg::CFG_MAX_OUT: drive_limit = data[dwips_pkg::MAX_W-1:0];
      default:                ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_gains(input logic [dwips_pkg::CFG_DAT_W-1:0] kp,
                           input logic [dwips_pkg::CFG_DAT_W-1:0] ki,
                           input logic [dwips_pkg::CFG_DAT_W-1:0] lim);
    settle();
    write_reg(dwips_pkg::CFG_KP, kp);
    write_reg(dwips_pkg::CFG_KI, ki);
    write_reg(dwips_pkg::CFG_MAX_OUT, lim);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset gains, corner speeds, stop ticks, most negative left count
  task automatic test_directed();
    send_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_tick(16'sd0, 16'sd0, 16'sd100, -16'sd50);
    send_tick(16'sd100, -16'sd100, -16'sd90, -16'sd95);
    send_tick(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_tick(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8001);
    send_tick(16'sd0, 16'sd5, 16'sd0, 16'sd0);
    send_tick(16'sd5, 16'sd0, 16'sd0, 16'sd0);
    send_tick(16'sd0, 16'sd0, 16'sh8000, 16'sh8000);
    send_tick(16'sh8000, 16'sh8000, 16'sh8001, 16'sh7FFF);
    send_tick(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
  endtask

  // Full gains with saturation, zero limit, dropped write, tiny gains
  task automatic test_registers();
    set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_tick(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_tick(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
    send_tick(16'sd3, -16'sd3, 16'sd0, 16'sd0);
    set_gains(16'hFFFF, 16'hFFFF, 16'h0000);
    send_tick(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_tick(16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0);
    settle();
    write_reg(CFG_UNMAPPED, 16'hA5A5);
    send_tick(16'sd200, 16'sd200, 16'sd0, 16'sd0);
    set_gains(16'h0000, 16'h0001, 16'h7FFF);
    send_tick(16'sd1, -16'sd1, 16'sd0, 16'sd0);
    send_tick(-16'sd700, 16'sd700, 16'sd0, 16'sd0);
    send_tick(16'sd0, 16'sd0, 16'sd1, 16'sd1);
    send_tick(-16'sd1, 16'sd1, 16'sd0, 16'sd0);
  endtask

  // Random ticks under a series of gain settings, one phase without gaps
  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_gains(16'd256, 16'd32, 16'd32767);
        1: set_gains(16'($urandom), 16'($urandom), 16'($urandom));
        2: set_gains(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 64)),
                     16'($urandom_range(100, 4000)));
        3: set_gains(16'($urandom_range(0, 512)), 16'($urandom_range(0, 512)),
                     16'($urandom));
        4: set_gains(16'($urandom), 16'($urandom_range(0, 8)),
                     16'($urandom_range(0, 3)));
        default: set_gains(16'($urandom_range(0, 4096)), 16'($urandom),
                           16'($urandom));
      endcase
      src_gaps_on  = (p != 3);
      sink_gaps_on = (p != 3);
      repeat (PhaseTicks) random_tick();
    end
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  // Receiver holds off for a long stretch while ticks keep coming
  task automatic test_output_backpressure();
    settle();
    src_gaps_on = 1'b0;
    hold_requests++;
    repeat (40) random_tick();
    src_gaps_on = 1'b1;
  endtask

  // Sender pauses until every result is back, then resumes
  task automatic test_drain_pause();
    repeat (20) random_tick();
    settle();
    repeat (20) random_tick();
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver: random hold-offs, plus long ones on request
  // ---------------------------------------------------------------------------
  initial begin : drive_sink
    int unsigned hold;
    drive_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_requests != holds_served) begin
        hold = LongHoldCycles;
        holds_served++;
      end else begin
        hold = sink_gaps_on ? $urandom_range(0, 5) : 0;
      end
      if (hold > 0) begin
        drive_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      drive_if.ready <= 1'b1;
      do @(posedge clk); while (!drive_if.valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Fields are compared as raw bits, zero-extended on both sides
  always @(posedge clk) begin : drive_check
    drive_beat_t want;
    if (rst_n && drive_if.valid && drive_if.ready) begin
      if (pending_drives.size() == 0) begin
        mismatches++;
        $display("%0t ns: result beat with none expected: expected nothing, actual %0h",
                 $time, {drive_if.drive_left, drive_if.drive_right, drive_if.stopped});
      end else begin
        want = pending_drives.pop_front();
        check_field("drive_left", 64'($unsigned(want.drive_left)),
                    64'($unsigned(drive_if.drive_left)));
        check_field("drive_right", 64'($unsigned(want.drive_right)),
                    64'($unsigned(drive_if.drive_right)));
        check_field("stopped", 64'(want.stopped), 64'(drive_if.stopped));
        check_field("position_left", 64'($unsigned(want.position_left)),
                    64'($unsigned(drive_if.position_left)));
        check_field("position_right", 64'($unsigned(want.position_right)),
                    64'($unsigned(drive_if.position_right)));
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (tick_if.valid && tick_if.ready) || (drive_if.valid && drive_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("%0t ns: watchdog, no beat accepted for %0d cycles", $time, StallLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk                   = 1'b0;
    rst_n                <= 1'b0;
    tick_if.valid         <= 1'b0;
    tick_if.target_left   <= '0;
    tick_if.target_right  <= '0;
    tick_if.encoder_left  <= '0;
    tick_if.encoder_right <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.index          <= '0;
    cfg_if.data           <= '0;
    kp_gain       = dwips_pkg::KP_RESET;
    ki_gain       = dwips_pkg::KI_RESET;
    drive_limit   = dwips_pkg::MAX_OUT_RESET;
    err_prev_l    = 0;
    err_prev_r    = 0;
    accum_l       = 0;
    accum_r       = 0;
    odo_l         = '0;
    odo_r         = '0;
    mismatches    = 0;
    quiet_cycles  = 0;
    src_gaps_on   = 1'b1;
    sink_gaps_on  = 1'b1;
    hold_requests = 0;
    holds_served  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_registers();
    test_random_phases();
    test_output_backpressure();
    test_drain_pause();
    settle();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
